@@ rtl/tone_melody_sequencer_assert.svh @@
// assertion macros used by the checker file
`ifndef TONE_MELODY_SEQUENCER_ASSERT_SVH
`define TONE_MELODY_SEQUENCER_ASSERT_SVH

// same-cycle implication, off while in reset
`define TMS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while in reset
`define TMS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// same-cycle implication, checked through reset as well
`define TMS_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/tms_pkg.sv @@
`default_nettype none

package tms_pkg;

   localparam int MAX_NOTES_DEF = 16;

   localparam int FUNC_W       = 3;
   localparam int NOTE_INDEX_W = 4;
   localparam int FREQ_W       = 16;
   localparam int DUR_W        = 32;
   localparam int LEN_W        = 8;
   localparam int POS_OUT_W    = 5;
   localparam int REQ_DATA_W   = 64;
   localparam int RSP_DATA_W   = 24;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK    = 3'd0,
      FUNC_LOAD    = 3'd1,
      FUNC_PLAY    = 3'd2,
      FUNC_BEEP    = 3'd3,
      FUNC_STOP    = 3'd4,
      FUNC_ENABLE  = 3'd5,
      FUNC_DISABLE = 3'd6
   } func_type;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [DUR_W-1:0]  dur;
   } note_type;

   // lowest bit is tone_on
   typedef struct packed {
      logic [POS_OUT_W-1:0] note_position;
      logic                 melody_active;
      logic                 busy_res;
      logic [FREQ_W-1:0]    tone_freq;
      logic                 tone_on;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/tms_note_mem.sv @@
`default_nettype none

module tms_note_mem import tms_pkg::*; #(
   parameter int DEPTH = MAX_NOTES_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire note_type      wr_data,
   input  wire logic [AW-1:0] rd_a_addr,
   input  wire logic [AW-1:0] rd_b_addr,
   output note_type           rd_a_data,
   output note_type           rd_b_data
);

   note_type note_mem_ff [DEPTH];
   note_type rd_a_ff;
   note_type rd_b_ff;
   note_type wr_data_ff;
   logic     byp_a_ff;
   logic     byp_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         note_mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff    <= note_mem_ff[rd_a_addr];
      rd_b_ff    <= note_mem_ff[rd_b_addr];
      wr_data_ff <= wr_data;
   end

   // forward a write that lands on an address read in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_a_ff <= 1'b0;
         byp_b_ff <= 1'b0;
      end else begin
         byp_a_ff <= wr_en && (wr_addr == rd_a_addr);
         byp_b_ff <= wr_en && (wr_addr == rd_b_addr);
      end
   end

   assign rd_a_data = byp_a_ff ? wr_data_ff : rd_a_ff;
   assign rd_b_data = byp_b_ff ? wr_data_ff : rd_b_ff;

endmodule

`default_nettype wire

@@ rtl/tms_seq_core.sv @@
`default_nettype none

module tms_seq_core import tms_pkg::*; #(
   parameter int MAX_NOTES = MAX_NOTES_DEF,
   parameter int AW        = $clog2(MAX_NOTES),
   parameter int PW        = $clog2(MAX_NOTES + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    exec,
   input  wire func_type                func,
   input  wire logic [NOTE_INDEX_W-1:0] note_index,
   input  wire logic [FREQ_W-1:0]       frequency,
   input  wire logic [DUR_W-1:0]        duration,
   input  wire logic [LEN_W-1:0]        melody_length,
   input  wire logic [FREQ_W-1:0]       rest_code,
   input  wire note_type                cur_note,
   input  wire note_type                next_note,
   output logic [PW-1:0]                note_pos_next,
   output logic                         wr_en,
   output logic [AW-1:0]                wr_addr,
   output note_type                     wr_data,
   output rsp_type                      result
);

   localparam int CW = (PW > NOTE_INDEX_W) ? PW : NOTE_INDEX_W;
   localparam int LW = (PW > LEN_W) ? PW : LEN_W;

   logic [PW-1:0]     melody_len_ff, melody_len_in;
   logic [PW-1:0]     note_pos_ff, note_pos_in;
   logic              melody_on_ff, melody_on_in;
   logic              beep_on_ff, beep_on_in;
   logic              sound_en_ff, sound_en_in;
   logic [DUR_W-1:0]  note_elapsed_ff, note_elapsed_in;
   logic [DUR_W-1:0]  beep_elapsed_ff, beep_elapsed_in;
   logic [DUR_W-1:0]  beep_limit_ff, beep_limit_in;
   logic              driving_ff, driving_in;
   logic [FREQ_W-1:0] driven_freq_ff, driven_freq_in;

   logic              halt;
   logic              note_start;
   logic [FREQ_W-1:0] note_freq;
   logic [DUR_W-1:0]  note_elapsed_inc;
   logic [DUR_W-1:0]  beep_elapsed_inc;
   logic [PW-1:0]     note_pos_inc;
   logic [LW-1:0]     len_wide;
   logic [CW-1:0]     index_wide;

   assign note_elapsed_inc = (note_elapsed_ff == '1) ? note_elapsed_ff
                                                     : note_elapsed_ff + DUR_W'(1);
   assign beep_elapsed_inc = (beep_elapsed_ff == '1) ? beep_elapsed_ff
                                                     : beep_elapsed_ff + DUR_W'(1);
   assign note_pos_inc = note_pos_ff + PW'(1);
   assign len_wide     = LW'(melody_length);
   assign index_wide   = CW'(note_index);

   assign wr_addr      = AW'(index_wide);
   assign wr_data.freq = frequency;
   assign wr_data.dur  = duration;

   always_comb begin
      melody_len_in   = melody_len_ff;
      note_pos_in     = note_pos_ff;
      melody_on_in    = melody_on_ff;
      beep_on_in      = beep_on_ff;
      sound_en_in     = sound_en_ff;
      note_elapsed_in = note_elapsed_ff;
      beep_elapsed_in = beep_elapsed_ff;
      beep_limit_in   = beep_limit_ff;
      driving_in      = driving_ff;
      driven_freq_in  = driven_freq_ff;
      halt            = 1'b0;
      note_start      = 1'b0;
      note_freq       = cur_note.freq;
      wr_en           = 1'b0;
      if (exec) begin
         unique case (func)
            FUNC_TICK: begin
               if (sound_en_ff && melody_on_ff) begin
                  note_elapsed_in = note_elapsed_inc;
                  if (note_elapsed_inc >= cur_note.dur) begin
                     note_pos_in = note_pos_inc;
                     if (note_pos_inc >= melody_len_ff) begin
                        halt = 1'b1;
                     end else begin
                        note_elapsed_in = '0;
                        note_start      = 1'b1;
                        note_freq       = next_note.freq;
                     end
                  end
               end else if (sound_en_ff && beep_on_ff) begin
                  beep_elapsed_in = beep_elapsed_inc;
                  if (beep_elapsed_inc >= beep_limit_ff) begin
                     halt = 1'b1;
                  end
               end
            end
            FUNC_LOAD: begin
               wr_en = (index_wide < CW'(MAX_NOTES));
            end
            FUNC_PLAY: begin
               if (sound_en_ff && (melody_length != '0)) begin
                  melody_len_in   = (len_wide > LW'(MAX_NOTES)) ? PW'(MAX_NOTES)
                                                               : PW'(len_wide);
                  note_pos_in     = '0;
                  melody_on_in    = 1'b1;
                  beep_on_in      = 1'b1;
                  note_elapsed_in = '0;
                  note_start      = 1'b1;
                  note_freq       = cur_note.freq;
               end
            end
            FUNC_BEEP: begin
               if (sound_en_ff) begin
                  beep_limit_in   = duration;
                  beep_elapsed_in = '0;
                  beep_on_in      = 1'b1;
                  if (frequency != '0) begin
                     driving_in     = 1'b1;
                     driven_freq_in = frequency;
                  end
               end
            end
            FUNC_STOP: begin
               halt = 1'b1;
            end
            FUNC_ENABLE: begin
               sound_en_in = 1'b1;
            end
            FUNC_DISABLE: begin
               sound_en_in = 1'b0;
               halt        = 1'b1;
            end
            default: begin
            end
         endcase
      end
      if (note_start) begin
         if (note_freq == rest_code) begin
            driving_in     = 1'b0;
            driven_freq_in = '0;
         end else if (note_freq != '0) begin
            driving_in     = 1'b1;
            driven_freq_in = note_freq;
         end
      end
      if (halt) begin
         beep_on_in     = 1'b0;
         melody_on_in   = 1'b0;
         driving_in     = 1'b0;
         driven_freq_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         melody_len_ff   <= '0;
         note_pos_ff     <= '0;
         melody_on_ff    <= 1'b0;
         beep_on_ff      <= 1'b0;
         sound_en_ff     <= 1'b1;
         note_elapsed_ff <= '0;
         beep_elapsed_ff <= '0;
         beep_limit_ff   <= '0;
         driving_ff      <= 1'b0;
         driven_freq_ff  <= '0;
      end else begin
         melody_len_ff   <= melody_len_in;
         note_pos_ff     <= note_pos_in;
         melody_on_ff    <= melody_on_in;
         beep_on_ff      <= beep_on_in;
         sound_en_ff     <= sound_en_in;
         note_elapsed_ff <= note_elapsed_in;
         beep_elapsed_ff <= beep_elapsed_in;
         beep_limit_ff   <= beep_limit_in;
         driving_ff      <= driving_in;
         driven_freq_ff  <= driven_freq_in;
      end
   end

   assign note_pos_next = note_pos_in;

   assign result.tone_on       = driving_in;
   assign result.tone_freq     = driving_in ? driven_freq_in : '0;
   assign result.busy_res      = beep_on_in || melody_on_in;
   assign result.melody_active = melody_on_in;
   assign result.note_position = POS_OUT_W'(note_pos_in);

endmodule

`default_nettype wire

@@ rtl/tone_melody_sequencer.sv @@
`default_nettype none

// Buzzer tone sequencer. Each command item on req_ (kind in req_tuser) gives exactly one
// status item on rsp_. Items are taken one per cycle while rsp_ does not stall; a command is
// executed once it sits in the input stage and the output register can take its status,
// which is then written there. Notes live in a MAX_NOTES deep store with two registered read
// ports: while a command waits in the input stage the store is read at the current note and
// the one after it, so a tick can both time out a note and start the next. Writes that hit an
// address read in the same cycle are forwarded. Notes must be loaded before a melody reaches
// them; the store is not cleared by reset. The rest code register must be written through
// csr_ only while the block is idle; the block itself does not enforce this.

module tone_melody_sequencer import tms_pkg::*; #(
   parameter int MAX_NOTES = MAX_NOTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // note_index, frequency, duration, melody_length, zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // func
   input  wire logic [FUNC_W-1:0]     req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tone_on, tone_freq, busy_res, melody_active, note_position
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [FREQ_W-1:0]     csr_data
);

   localparam int AW = $clog2(MAX_NOTES);
   localparam int PW = $clog2(MAX_NOTES + 1);

   logic                    x_valid_ff, x_valid_in;
   func_type                x_func_ff;
   logic [NOTE_INDEX_W-1:0] x_index_ff;
   logic [FREQ_W-1:0]       x_freq_ff;
   logic [DUR_W-1:0]        x_dur_ff;
   logic [LEN_W-1:0]        x_len_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff;
   logic [FREQ_W-1:0]       rest_code_ff;

   logic          exec;
   logic          accept;
   func_type      next_func;
   logic [PW-1:0] note_pos_next;
   logic [AW-1:0] rd_a_addr;
   logic [AW-1:0] rd_b_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   note_type      wr_data;
   note_type      cur_note;
   note_type      next_note;
   rsp_type       result;

   assign exec       = x_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !x_valid_ff || exec;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign x_valid_in   = accept || (x_valid_ff && !exec);
   assign rsp_valid_in = exec || (rsp_valid_ff && !rsp_tready);

   // address for the item that sits in the input stage next cycle
   assign next_func = accept ? func_type'(req_tuser) : x_func_ff;
   assign rd_a_addr = (next_func == FUNC_PLAY) ? '0 : AW'(note_pos_next);
   assign rd_b_addr = AW'(note_pos_next + PW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rest_code_ff <= '0;
      end else begin
         x_valid_ff   <= x_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            rest_code_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_func_ff  <= func_type'(req_tuser);
         x_index_ff <= req_tdata[NOTE_INDEX_W-1:0];
         x_freq_ff  <= req_tdata[NOTE_INDEX_W +: FREQ_W];
         x_dur_ff   <= req_tdata[NOTE_INDEX_W + FREQ_W +: DUR_W];
         x_len_ff   <= req_tdata[NOTE_INDEX_W + FREQ_W + DUR_W +: LEN_W];
      end
      if (exec) begin
         rsp_data_ff <= result;
      end
   end

   tms_note_mem #(
      .DEPTH (MAX_NOTES),
      .AW    (AW)
   ) u_note_mem (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (cur_note),
      .rd_b_data (next_note)
   );

   tms_seq_core #(
      .MAX_NOTES (MAX_NOTES),
      .AW        (AW),
      .PW        (PW)
   ) u_seq_core (
      .clock         (clock),
      .reset         (reset),
      .exec          (exec),
      .func          (x_func_ff),
      .note_index    (x_index_ff),
      .frequency     (x_freq_ff),
      .duration      (x_dur_ff),
      .melody_length (x_len_ff),
      .rest_code     (rest_code_ff),
      .cur_note      (cur_note),
      .next_note     (next_note),
      .note_pos_next (note_pos_next),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .result        (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

@@ rtl/tms_checker.sv @@
`default_nettype none

`include "tone_melody_sequencer_assert.svh"

module tms_checker import tms_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   `TMS_ASSERT_IMPLY(a_silent_freq_zero, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[FREQ_W:1] == '0, "tone off with nonzero frequency")
   `TMS_ASSERT_IMPLY(a_melody_is_busy, clock, reset, rsp_tvalid && rsp_tdata[FREQ_W+2], rsp_tdata[FREQ_W+1], "melody active without busy")
   `TMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled item changed")
   `TMS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "item shown right after reset")

endmodule

bind tone_melody_sequencer tms_checker u_tms_checker (.*);

`default_nettype wire
